### hw/rtl/bwm_pkg.sv
// Shared types, codes and match functions of the breakpoint/watchpoint matcher.
`default_nettype none
package bwm_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 8;
  localparam int unsigned IDX_W           = 3;
  localparam int unsigned MASK_W          = 8;

  typedef enum logic [1:0] {
    OP_CHECK   = 2'd0,
    OP_WRITE   = 2'd1,
    OP_ARM_CPU = 2'd2,
    OP_ARM_PPU = 2'd3
  } opcode_t;

  localparam logic TARGET_CPU = 1'b0;
  localparam logic TARGET_PPU = 1'b1;

  localparam logic [3:0] KIND_PPU_CYCLE      = 4'd0;
  localparam logic [3:0] KIND_CPU_EXEC       = 4'd1;
  localparam logic [3:0] KIND_CPU_ANY        = 4'd2;
  localparam logic [3:0] KIND_CPU_READ       = 4'd3;
  localparam logic [3:0] KIND_CPU_WRITE      = 4'd4;
  localparam logic [3:0] KIND_OAM_ANY        = 4'd5;
  localparam logic [3:0] KIND_OAM_READ       = 4'd6;
  localparam logic [3:0] KIND_OAM_WRITE      = 4'd7;
  localparam logic [3:0] KIND_PPU_FETCH      = 4'd8;
  localparam logic [3:0] KIND_PPU_PORT_ANY   = 4'd9;
  localparam logic [3:0] KIND_PPU_PORT_READ  = 4'd10;
  localparam logic [3:0] KIND_PPU_PORT_WRITE = 4'd11;

  localparam logic [2:0] COND_ANY     = 3'd0;
  localparam logic [2:0] COND_EQUAL   = 3'd1;
  localparam logic [2:0] COND_NEQUAL  = 3'd2;
  localparam logic [2:0] COND_LESS    = 3'd3;
  localparam logic [2:0] COND_GREATER = 3'd4;

  typedef struct packed {
    opcode_t     opcode;
    logic        target;
    logic [3:0]  access_kind;
    logic [15:0] address;
    logic        sync;
    logic [7:0]  data_value;
    logic [2:0]  entry_index;
    logic        entry_enabled;
    logic [2:0]  entry_condition;
    logic [15:0] entry_low;
    logic [15:0] entry_high;
  } cmd_t;

  typedef struct packed {
    logic        break_now;
    logic [7:0]  hit_mask;
    logic [15:0] matched_address;
  } result_t;

  typedef struct packed {
    logic        enabled;
    logic        target;
    logic [3:0]  kind;
    logic [2:0]  condition;
    logic [15:0] low;
    logic [15:0] high;
    logic [7:0]  data;
  } entry_t;

  // Event plus the partial outcome gathered by the cells already passed.
  typedef struct packed {
    logic        target;
    logic [3:0]  kind;
    logic [15:0] address;
    logic        sync;
    logic [7:0]  data;
    logic        brk;
    logic [MASK_W-1:0] mask;
    logic        range_hit;
  } token_t;

  function automatic logic kind_matches(input logic [3:0] ek, input logic [3:0] ev);
    logic m;
    m = (ek == ev);
    case (ek)
      KIND_CPU_ANY:      m = m || ev == KIND_CPU_READ || ev == KIND_CPU_WRITE;
      KIND_OAM_ANY:      m = m || ev == KIND_OAM_READ || ev == KIND_OAM_WRITE;
      KIND_PPU_PORT_ANY: m = m || ev == KIND_PPU_PORT_READ || ev == KIND_PPU_PORT_WRITE;
      default:           m = m;
    endcase
    return m;
  endfunction

  function automatic logic cond_holds(input logic [2:0] cond, input logic [7:0] d,
                                      input logic [7:0] ref_d);
    logic h;
    case (cond)
      COND_ANY:     h = 1'b1;
      COND_EQUAL:   h = (d == ref_d);
      COND_NEQUAL:  h = (d != ref_d);
      COND_LESS:    h = (d < ref_d);
      COND_GREATER: h = (d > ref_d);
      default:      h = 1'b0;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/bwm_cell.sv
// One table entry of the matcher chain: holds the entry, compares the passing event.
`default_nettype none
module bwm_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire bwm_pkg::entry_t wr_entry,
  input  wire logic            tok_in_valid,
  input  wire bwm_pkg::token_t tok_in,
  output logic                 tok_out_valid,
  output bwm_pkg::token_t      tok_out
);

  bwm_pkg::entry_t entry;
  bwm_pkg::token_t tok_next;
  logic            sel;
  logic            in_range;
  logic            hit;
  logic            range_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr_en) begin
      entry <= wr_entry;
    end
  end

  always_comb begin
    sel = entry.enabled && (entry.target == tok_in.target) &&
          bwm_pkg::kind_matches(entry.kind, tok_in.kind);
    in_range  = (tok_in.address >= entry.low) && (tok_in.address <= entry.high);
    hit       = 1'b0;
    range_hit = 1'b0;
    if (sel) begin
      if (entry.kind == bwm_pkg::KIND_CPU_EXEC) begin
        hit       = tok_in.sync && in_range;
        range_hit = hit;
      end else if (entry.kind >= bwm_pkg::KIND_CPU_ANY &&
                   entry.kind <= bwm_pkg::KIND_PPU_PORT_WRITE) begin
        range_hit = in_range;
        hit       = in_range &&
                    bwm_pkg::cond_holds(entry.condition, tok_in.data, entry.data);
      end
    end
  end

  generate
    if (INDEX < bwm_pkg::MASK_W) begin : g_mask
      always_comb begin
        tok_next           = tok_in;
        tok_next.brk       = tok_in.brk || hit;
        tok_next.range_hit = tok_in.range_hit || range_hit;
        tok_next.mask[INDEX] = hit;
      end
    end else begin : g_nomask
      always_comb begin
        tok_next           = tok_in;
        tok_next.brk       = tok_in.brk || hit;
        tok_next.range_hit = tok_in.range_hit || range_hit;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule
`default_nettype wire

### hw/rtl/breakpoint_watchpoint_matcher_unit.sv
// Latency: a check transaction passes one register per entry cell and then the
// output register; write, arm and step-break transactions answer in the next cycle.
// Throughput: busy stays high while a check travels the cell chain, so no new transaction
// is taken until that check has left the chain; other transactions one per cycle while busy is low.
// Reset: synchronous, clears the table, both step flags and the chain; results cannot
// be stalled by the receiver.
`default_nettype none
module breakpoint_watchpoint_matcher_unit #(
  parameter int unsigned NUM_ENTRIES = bwm_pkg::NUM_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire bwm_pkg::cmd_t cmd,
  output logic               done,
  output bwm_pkg::result_t   result
);

  logic [NUM_ENTRIES:0] tok_v;
  bwm_pkg::token_t      tok [NUM_ENTRIES+1];

  logic             accept;
  logic             cpu_armed, cpu_armed_next;
  logic             ppu_armed, ppu_armed_next;
  logic             direct;
  logic             direct_brk;
  logic             launch;
  logic             done_next;
  bwm_pkg::result_t result_next;
  bwm_pkg::entry_t  wr_entry;
  logic             cpu_step, ppu_step;

  assign busy   = |tok_v[NUM_ENTRIES:1];
  assign accept = start && !busy;

  assign cpu_step = cpu_armed && cmd.target == bwm_pkg::TARGET_CPU &&
                    cmd.access_kind == bwm_pkg::KIND_CPU_EXEC;
  assign ppu_step = ppu_armed && cmd.target == bwm_pkg::TARGET_PPU &&
                    cmd.access_kind == bwm_pkg::KIND_PPU_CYCLE;

  always_comb begin
    cpu_armed_next = cpu_armed;
    ppu_armed_next = ppu_armed;
    direct         = 1'b0;
    direct_brk     = 1'b0;
    launch         = 1'b0;
    if (accept) begin
      unique case (cmd.opcode)
        bwm_pkg::OP_WRITE:   direct = 1'b1;
        bwm_pkg::OP_ARM_CPU: begin
          direct         = 1'b1;
          cpu_armed_next = 1'b1;
        end
        bwm_pkg::OP_ARM_PPU: begin
          direct         = 1'b1;
          ppu_armed_next = 1'b1;
        end
        bwm_pkg::OP_CHECK: begin
          if (cpu_step) begin
            direct         = 1'b1;
            direct_brk     = 1'b1;
            cpu_armed_next = 1'b0;
          end else if (ppu_step) begin
            direct         = 1'b1;
            direct_brk     = 1'b1;
            ppu_armed_next = 1'b0;
          end else begin
            launch = 1'b1;
          end
        end
        default: direct = 1'b1;
      endcase
    end
  end

  always_comb begin
    wr_entry.enabled   = cmd.entry_enabled;
    wr_entry.target    = cmd.target;
    wr_entry.kind      = cmd.access_kind;
    wr_entry.condition = cmd.entry_condition;
    wr_entry.low       = cmd.entry_low;
    wr_entry.high      = cmd.entry_high;
    wr_entry.data      = cmd.data_value;
  end

  // Launch the event into the head of the chain with an empty outcome.
  assign tok_v[0]            = launch;
  assign tok[0].target       = cmd.target;
  assign tok[0].kind         = cmd.access_kind;
  assign tok[0].address      = cmd.address;
  assign tok[0].sync         = cmd.sync;
  assign tok[0].data         = cmd.data_value;
  assign tok[0].brk          = 1'b0;
  assign tok[0].mask         = '0;
  assign tok[0].range_hit    = 1'b0;

  generate
    for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      logic wr_en;
      if (i < (1 << bwm_pkg::IDX_W)) begin : g_wr
        assign wr_en = accept && cmd.opcode == bwm_pkg::OP_WRITE &&
                       cmd.entry_index == bwm_pkg::IDX_W'(i);
      end else begin : g_nowr
        assign wr_en = 1'b0;
      end
      bwm_cell #(.INDEX(i)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .wr_en        (wr_en),
        .wr_entry     (wr_entry),
        .tok_in_valid (tok_v[i]),
        .tok_in       (tok[i]),
        .tok_out_valid(tok_v[i+1]),
        .tok_out      (tok[i+1])
      );
    end
  endgenerate

  always_comb begin
    done_next   = direct || tok_v[NUM_ENTRIES];
    result_next = '0;
    if (direct) begin
      result_next.break_now = direct_brk;
    end else begin
      result_next.break_now       = tok[NUM_ENTRIES].brk;
      result_next.hit_mask        = tok[NUM_ENTRIES].mask;
      result_next.matched_address = tok[NUM_ENTRIES].range_hit ?
                                    tok[NUM_ENTRIES].address : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_armed <= 1'b0;
      ppu_armed <= 1'b0;
      done      <= 1'b0;
    end else begin
      cpu_armed <= cpu_armed_next;
      ppu_armed <= ppu_armed_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_v[NUM_ENTRIES:1]))
    else $error("more than one check transaction in the cell chain");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while a check is still in the chain");

  a_cpu_step: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == bwm_pkg::OP_CHECK && cpu_step
    |=> done && result.break_now && result.hit_mask == '0 && !cpu_armed)
    else $error("armed cpu step did not break and clear");

  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode != bwm_pkg::OP_CHECK
    |=> done && !result.break_now && result.matched_address == '0)
    else $error("write or arm transaction gave a nonzero result");

endmodule
`default_nettype wire
